[rtl/core/spr_pkg.sv]
// Shared constants, types and the percent-to-duty table of the servo ramp controller.
package spr_pkg;

  localparam int unsigned US_AT_ZERO = 544;
  localparam int unsigned US_SPAN    = 1956;
  localparam int unsigned PCT_SCALE  = 100;
  localparam int unsigned PERIOD_US  = 20000;
  localparam int unsigned DUTY_FULL  = 4095;
  localparam int unsigned DUTY_AT_ZERO = 111;
  localparam int unsigned RAMP_DIV   = 400;

  localparam int unsigned DUTY_W = 12;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned FS_W   = 20;
  localparam int unsigned LEN_W  = 21;
  localparam int unsigned PROD_W = DUTY_W + LEN_W;
  localparam int unsigned DVD_W  = PROD_W + 1;
  localparam int unsigned DVS_W  = LEN_W;
  localparam int unsigned PCT_ENTRIES = 2 ** PCT_W;
  localparam int unsigned PCT_MAX = 100;

  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_GOTO   = 2'd1;
  localparam logic [1:0] FUNC_HALT   = 2'd2;
  localparam logic [1:0] FUNC_STATUS = 2'd3;

  typedef logic [DUTY_W-1:0] duty_tbl_t [PCT_ENTRIES];

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic duty_tbl_t build_duty_tbl();
    duty_tbl_t   tbl;
    int unsigned us;
    for (int p = 0; p < PCT_ENTRIES; p++) begin
      us = (p * US_SPAN) / PCT_SCALE + US_AT_ZERO;
      tbl[p] = DUTY_W'((us * DUTY_FULL) / PERIOD_US);
    end
    return tbl;
  endfunction

  localparam duty_tbl_t DUTY_TBL = build_duty_tbl();

endpackage

[rtl/core/spr_divider.sv]
// Restoring serial divider, one quotient bit per cycle.
module spr_divider
  import spr_pkg::*;
#(
  parameter int unsigned DvdW = DVD_W,
  parameter int unsigned DvsW = DVS_W
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic [DvdW-1:0] quotient_o,
  output div_stat_t       stat_o
);

  localparam int unsigned CntW = $clog2(DvdW + 1);

  logic [DvsW-1:0] rem_q;
  logic [DvsW-1:0] dvs_q;
  logic [DvdW-1:0] quo_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;

  logic [DvsW:0]   shifted;
  logic [DvsW+1:0] diff;
  logic            ge;

  always_comb begin
    shifted = {rem_q, quo_q[DvdW-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_q};
    ge      = ~diff[DvsW+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DvdW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DvsW-1:0] : shifted[DvsW-1:0];
      quo_q <= {quo_q[DvdW-2:0], ge};
    end
  end

  assign quotient_o = quo_q;
  assign stat_o     = '{busy: busy_q, done: done_q};

endmodule

[rtl/core/servo_pwm_ramp_controller_core.sv]
// Servo PWM duty controller with linear position ramp: sequencer, state and ports.
//
// One input channel (in_valid_i / in_stall_o) carries a function code: a 1 ms tick,
// a goto with percentage, direct_move and override_position, a halt, or a status
// read. Every accepted beat yields exactly one result beat on the output channel
// (out_valid_o / out_stall_i) with duty, position, status_value, moving, accepted.
// full_stroke_ms is written through the APB port at byte address 0.
// Halt, status, rejected gotos, gotos that jump straight to the target, ticks outside
// a ramp and ramp-ending ticks go from the exec state directly to the output state.
// A goto that starts a ramp and a tick inside a ramp pass through a 12x21 multiply,
// then the shared 34-bit serial divider, one quotient bit per cycle (dividing by 400
// for the ramp length, by the ramp length for the interpolated duty).
// in_stall_o is high while an item is in work.
// The result sits in an output register; the next item is accepted while it
// waits, but its own result is held back until the receiver takes the previous.
// Reset clears all duty and ramp state and full_stroke_ms; the position of the cleared duty is -28.
module servo_pwm_ramp_controller_core
  import spr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        func_i,
  input  logic [PCT_W-1:0]  percentage_i,
  input  logic              direct_move_i,
  input  logic              override_position_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DUTY_W-1:0] duty_o,
  output logic signed [7:0] position_o,
  output logic signed [7:0] status_value_o,
  output logic              moving_o,
  output logic              accepted_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } state_e;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  function automatic logic signed [11:0] pos_of(input logic [DUTY_W-1:0] d);
    logic signed [12:0] v;
    logic        [12:0] mag;
    v = $signed({1'b0, d}) - 13'sd111;
    if (v >= 0) begin
      mag = 13'(v + 13'sd2) >> 2;
      return 12'(mag);
    end
    mag = 13'(13'sd2 - v) >> 2;
    return -$signed(12'(mag));
  endfunction

  state_e             state_q;
  logic [FS_W-1:0]    full_stroke_q;
  logic [1:0]         func_q;
  logic [PCT_W-1:0]   pct_q;
  logic               direct_q;
  logic               ovr_in_q;

  logic [DUTY_W-1:0]  duty_q;
  logic               ramp_q;
  logic               override_q;
  logic [DUTY_W-1:0]  start_q;
  logic [DUTY_W-1:0]  dest_q;
  logic [PCT_W-1:0]   dest_pct_q;
  logic [LEN_W-1:0]   len_q;
  logic [LEN_W-1:0]   elapsed_q;
  logic               job_tick_q;
  logic               down_q;
  logic               accepted_q;

  logic [DUTY_W-1:0]  mul_a_q;
  logic [LEN_W-1:0]   mul_b_q;
  logic [PROD_W-1:0]  prod_q;

  logic               out_valid_q;
  logic [DUTY_W-1:0]  out_duty_q;
  logic [7:0]         out_pos_q;
  logic [7:0]         out_stat_q;
  logic               out_moving_q;
  logic               out_acc_q;

  logic               in_accept;
  logic               cfg_write;
  logic [LEN_W-1:0]   e_inc;
  logic [DUTY_W-1:0]  target;
  logic [DUTY_W-1:0]  travel;
  logic [DUTY_W-1:0]  ramp_span;
  logic signed [11:0] cur_pos;
  logic               jump;
  logic               div_start;
  logic [DVD_W-1:0]   div_dividend;
  logic [DVS_W-1:0]   div_divisor;
  logic [DVD_W-1:0]   div_quot;
  div_stat_t          div_stat;
  logic signed [11:0] out_pos_full;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign pready     = 1'b1;
  assign cfg_write  = psel & penable & pwrite;
  assign prdata     = paddr[2] ? 32'd0 : {{(32-FS_W){1'b0}}, full_stroke_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_stroke_q <= '0;
    end else if (cfg_write && !paddr[2]) begin
      full_stroke_q <= pwdata[FS_W-1:0];
    end
  end

  always_comb begin
    e_inc     = (elapsed_q < LEN_MAX) ? elapsed_q + LEN_W'(1) : elapsed_q;
    target    = DUTY_TBL[pct_q];
    travel    = (target > duty_q) ? target - duty_q : duty_q - target;
    ramp_span = (dest_q >= start_q) ? dest_q - start_q : start_q - dest_q;
    cur_pos   = pos_of(duty_q);
    jump      = (cur_pos < 0) || (cur_pos > 12'sd100) || direct_q ||
                (full_stroke_q == '0);
    div_start = (state_q == ST_LOAD);
    div_dividend = {1'b0, prod_q} +
                   (down_q ? DVD_W'(len_q - LEN_W'(1)) : DVD_W'(0));
    div_divisor  = job_tick_q ? len_q : DVS_W'(RAMP_DIV);
    out_pos_full = pos_of(duty_q);
  end

  spr_divider #(
    .DvdW (DVD_W),
    .DvsW (DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quot),
    .stat_o     (div_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      duty_q      <= '0;
      ramp_q      <= 1'b0;
      override_q  <= 1'b0;
      start_q     <= '0;
      dest_q      <= '0;
      dest_pct_q  <= '0;
      len_q       <= '0;
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            func_q   <= func_i;
            pct_q    <= percentage_i;
            direct_q <= direct_move_i;
            ovr_in_q <= override_position_i;
            state_q  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          accepted_q <= 1'b1;
          state_q    <= ST_OUT;
          unique case (func_q)
            FUNC_TICK: begin
              if (!ramp_q) begin
                override_q <= 1'b0;
              end else if (e_inc >= len_q) begin
                elapsed_q <= e_inc;
                duty_q    <= dest_q;
                ramp_q    <= 1'b0;
              end else begin
                elapsed_q  <= e_inc;
                mul_a_q    <= ramp_span;
                mul_b_q    <= e_inc;
                job_tick_q <= 1'b1;
                down_q     <= (dest_q < start_q);
                state_q    <= ST_MUL;
              end
            end
            FUNC_GOTO: begin
              if (pct_q > PCT_W'(PCT_MAX)) begin
                accepted_q <= 1'b0;
              end else if (jump) begin
                duty_q <= target;
              end else begin
                start_q    <= duty_q;
                dest_q     <= target;
                dest_pct_q <= pct_q;
                elapsed_q  <= '0;
                ramp_q     <= 1'b1;
                override_q <= ovr_in_q;
                mul_a_q    <= travel;
                mul_b_q    <= LEN_W'(full_stroke_q);
                job_tick_q <= 1'b0;
                down_q     <= 1'b0;
                state_q    <= ST_MUL;
              end
            end
            FUNC_HALT: begin
              ramp_q <= 1'b0;
            end
            FUNC_STATUS: begin
            end
            default: begin
            end
          endcase
        end
        ST_MUL: begin
          prod_q  <= PROD_W'(mul_a_q) * PROD_W'(mul_b_q);
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            if (job_tick_q) begin
              duty_q <= down_q ? start_q - div_quot[DUTY_W-1:0]
                               : start_q + div_quot[DUTY_W-1:0];
            end else begin
              len_q <= div_quot[LEN_W-1:0];
            end
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_duty_q   <= duty_q;
            out_pos_q    <= out_pos_full[7:0];
            out_stat_q   <= override_q ? {1'b0, dest_pct_q} : out_pos_full[7:0];
            out_moving_q <= ramp_q;
            out_acc_q    <= accepted_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign duty_o         = out_duty_q;
  assign position_o     = $signed(out_pos_q);
  assign status_value_o = $signed(out_stat_q);
  assign moving_o       = out_moving_q;
  assign accepted_o     = out_acc_q;

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIV))
    else $error("divider finished outside its wait state");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("input not stalled after accepting a beat");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result beat raised outside the output state");

  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

endmodule
